FILE: sv/thermal_step_controller_macros.svh
// Assertion helpers shared by the thermal step controller.
`ifndef THERMAL_STEP_CONTROLLER_MACROS_SVH
`define THERMAL_STEP_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermal_step_controller: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermal_step_controller: next-cycle check failed");

`endif

FILE: sv/tsc_pkg.sv
package tsc_pkg;

    // Field widths.
    localparam int ADC_WIDTH   = 12;
    localparam int TEMP_WIDTH  = 10;
    localparam int LEVEL_WIDTH = 8;
    localparam int DUTY_WIDTH  = 8;
    localparam int QUOT_WIDTH  = 9;
    localparam int NUM_WIDTH   = 18;

    // Default number of samples per average.
    localparam int SAMPLES_PER_AVERAGE = 4;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Register reset value.
    localparam logic signed [TEMP_WIDTH-1:0] TARGET_RESET = 10'sd28;

    // Conversion constants: avg*250/4096 and (142 - scaled)*1000/435 + 25.
    localparam logic [7:0]  SCALE_MULT  = 8'd250;
    localparam int          SCALE_SHIFT = 12;
    localparam logic [8:0]  TEMP_OFFSET = 9'd142;
    localparam logic [9:0]  DEG_NUM     = 10'd1000;
    localparam int          DEG_DEN     = 435;
    localparam int          DEG_SHIFT   = 27;
    localparam int          DEG_MULT_WIDTH = 19;
    localparam logic [DEG_MULT_WIDTH-1:0] DEG_MULT =
        DEG_MULT_WIDTH'(((64'd1 << DEG_SHIFT) + 64'(DEG_DEN) - 64'd1) / 64'(DEG_DEN));
    localparam logic signed [TEMP_WIDTH-1:0] TEMP_BIAS = 10'sd25;

    // Control level limits.
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_CENTER = 8'd128;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MIN    = 8'd2;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX    = 8'd254;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_LOW_STEP  = 8'd3;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_HIGH_STEP = 8'd253;

    // Duty limits for each drive direction.
    localparam logic [LEVEL_WIDTH-1:0] DIR_HIGH_MAG_CAP  = 8'd82;
    localparam logic [DUTY_WIDTH-1:0]  DIR_HIGH_DUTY_CAP = 8'd252;
    localparam logic [LEVEL_WIDTH-1:0] DIR_LOW_MAG_CAP   = 8'd125;
    localparam logic [DUTY_WIDTH-1:0]  DIR_LOW_DUTY_CAP  = 8'd250;

    // Drive direction codes.
    localparam logic DIR_HIGH = 1'b0;
    localparam logic DIR_LOW  = 1'b1;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCALE,
        BK_MAG,
        BK_QUOT,
        BK_LEVEL,
        BK_PUSH
    } tsc_back_state_t;

endpackage

FILE: sv/tsc_sample_if.sv
interface tsc_sample_if;

    logic                            valid;
    logic                            ready;
    logic [tsc_pkg::ADC_WIDTH-1:0]   adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);

endinterface

FILE: sv/tsc_result_if.sv
interface tsc_result_if;

    logic                                   valid;
    logic                                   ready;
    logic [tsc_pkg::DUTY_WIDTH-1:0]         duty;
    logic                                   direction;
    logic signed [tsc_pkg::TEMP_WIDTH-1:0]  temperature;
    logic [tsc_pkg::LEVEL_WIDTH-1:0]        control_level;

    modport source (output valid, output duty, output direction, output temperature,
                    output control_level, input ready);
    modport sink   (input valid, input duty, input direction, input temperature,
                    input control_level, output ready);

endinterface

FILE: sv/thermal_step_controller.sv
// The transaction that closes a group queues its sum; the back sequencer pops it, passes it through the
// scale, magnitude, quotient and level states and loads the output register in the push state once any
// previous result has been taken. The front takes one sample transaction per cycle, but one that closes
// a group waits while the two-entry queue to the sequencer is full; the queue absorbs short bursts.
// Reset (rst_n low, asynchronous): sum and count clear, level 128, direction 0, target 28.
`include "thermal_step_controller_macros.svh"

module thermal_step_controller #(
    parameter int SAMPLES_PER_AVERAGE = tsc_pkg::SAMPLES_PER_AVERAGE
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic signed [tsc_pkg::TEMP_WIDTH-1:0]  cfg_wdata,
    tsc_sample_if.sink                             samples,
    tsc_result_if.source                           results
);

    localparam int SumWidth = tsc_pkg::ADC_WIDTH + $clog2(SAMPLES_PER_AVERAGE);

    logic signed [tsc_pkg::TEMP_WIDTH-1:0] target_reg;
    logic                 push;
    logic [SumWidth-1:0]  push_sum;
    logic                 pop;
    logic [SumWidth-1:0]  pop_sum;
    logic                 queue_full;
    logic                 queue_empty;

    // Target temperature register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= tsc_pkg::TARGET_RESET;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    // Front: accumulates samples and queues each finished group sum.
    tsc_front #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SUM_WIDTH           (SumWidth)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .queue_full (queue_full),
        .push       (push),
        .push_sum   (push_sum)
    );

    // Queue of group sums.
    tsc_fifo #(
        .WIDTH (SumWidth),
        .DEPTH (tsc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_sum),
        .pop       (pop),
        .pop_data  (pop_sum),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back: conversion, level step and result output.
    tsc_back #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SUM_WIDTH           (SumWidth)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .target      (target_reg),
        .queue_empty (queue_empty),
        .queue_sum   (pop_sum),
        .pop         (pop),
        .results     (results)
    );

    // Queue is never overrun or read while empty.
    `TSC_ASSERT_SAME(a_no_push_full, push, !queue_full)
    `TSC_ASSERT_SAME(a_no_pop_empty, pop, !queue_empty)
    // Reported level stays inside the clamp and matches the reported direction and duty.
    `TSC_ASSERT_SAME(a_level_range, results.valid, (results.control_level >= tsc_pkg::LEVEL_MIN) && (results.control_level <= tsc_pkg::LEVEL_MAX))
    `TSC_ASSERT_SAME(a_center_duty, results.valid && (results.control_level == tsc_pkg::LEVEL_CENTER), results.duty == '0)
    `TSC_ASSERT_SAME(a_high_dir, results.valid && (results.control_level > tsc_pkg::LEVEL_CENTER), results.direction == tsc_pkg::DIR_HIGH)

endmodule

FILE: sv/tsc_fifo.sv
module tsc_fifo #(
    parameter int WIDTH = 14,
    parameter int DEPTH = tsc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      mem [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg;
    logic [PtrWidth-1:0]   rd_ptr_reg;
    logic [CountWidth-1:0] count_reg;

    assign full     = (count_reg == CountWidth'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Storage is written at the tail pointer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers wrap at the queue depth; the count tracks occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/tsc_front.sv
module tsc_front #(
    parameter int SAMPLES_PER_AVERAGE = tsc_pkg::SAMPLES_PER_AVERAGE,
    parameter int SUM_WIDTH = tsc_pkg::ADC_WIDTH + $clog2(SAMPLES_PER_AVERAGE)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tsc_sample_if.sink           samples,
    input  logic                 queue_full,
    output logic                 push,
    output logic [SUM_WIDTH-1:0] push_sum
);

    localparam int CountWidth = $clog2(SAMPLES_PER_AVERAGE);

    logic [SUM_WIDTH-1:0]  sum_reg;
    logic [CountWidth-1:0] count_reg;
    logic                  last;
    logic                  accept;
    logic [SUM_WIDTH-1:0]  sum_next;

    // A transaction that closes a group needs room in the queue.
    assign last     = (count_reg == CountWidth'(SAMPLES_PER_AVERAGE - 1));
    assign samples.ready = !(last && queue_full);
    assign accept   = samples.valid && samples.ready;
    assign sum_next = sum_reg + SUM_WIDTH'(samples.adc_sample);
    assign push     = accept && last;
    assign push_sum = sum_next;

    // Running sum and sample counter for the current group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

endmodule

FILE: sv/tsc_back.sv
module tsc_back #(
    parameter int SAMPLES_PER_AVERAGE = tsc_pkg::SAMPLES_PER_AVERAGE,
    parameter int SUM_WIDTH = tsc_pkg::ADC_WIDTH + $clog2(SAMPLES_PER_AVERAGE)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [tsc_pkg::TEMP_WIDTH-1:0]  target,
    input  logic                                   queue_empty,
    input  logic [SUM_WIDTH-1:0]                   queue_sum,
    output logic                                   pop,
    tsc_result_if.source                           results
);

    // Division by the group size as a reciprocal multiply, exact for all sums.
    localparam int CountWidth = $clog2(SAMPLES_PER_AVERAGE);
    localparam int AvgShift   = SUM_WIDTH + CountWidth;
    localparam int MultWidth  = SUM_WIDTH + 1;
    localparam int ProdWidth  = SUM_WIDTH + MultWidth;
    localparam logic [MultWidth-1:0] AvgMult = MultWidth'(
        ((64'd1 << AvgShift) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE));

    localparam int AW = tsc_pkg::ADC_WIDTH;
    localparam int LW = tsc_pkg::LEVEL_WIDTH;
    localparam int TW = tsc_pkg::TEMP_WIDTH;
    localparam int QW = tsc_pkg::QUOT_WIDTH;
    localparam int NW = tsc_pkg::NUM_WIDTH;
    localparam int DW = tsc_pkg::DEG_MULT_WIDTH;

    tsc_pkg::tsc_back_state_t state_reg, state_next;

    logic [ProdWidth-1:0]  prod_reg;
    logic [7:0]            scaled_reg;
    logic                  neg_reg;
    logic [NW-1:0]         num_reg;
    logic [QW-1:0]         quot_reg;
    logic signed [TW-1:0]  temp_reg;
    logic [LW-1:0]         level_reg, level_next;
    logic                  dir_reg, dir_next;

    logic                  out_valid_reg, out_valid_next;
    logic [tsc_pkg::DUTY_WIDTH-1:0] out_duty_reg;
    logic                  out_dir_reg;
    logic signed [TW-1:0]  out_temp_reg;
    logic [LW-1:0]         out_level_reg;

    logic [AW-1:0]         avg;
    logic [AW+7:0]         scale_prod;
    logic signed [8:0]     diff;
    logic signed [8:0]     diff_neg;
    logic [7:0]            mag_deg;
    logic [NW+DW-1:0]      deg_prod;
    logic signed [TW-1:0]  temp;
    logic [LW-1:0]         mag;
    logic                  dir;
    logic [tsc_pkg::DUTY_WIDTH-1:0] duty;
    logic                  out_load;

    // Datapath arithmetic between the sequencer registers.
    assign avg        = prod_reg[AvgShift +: AW];
    assign scale_prod = avg * tsc_pkg::SCALE_MULT;
    assign diff       = $signed(tsc_pkg::TEMP_OFFSET) - $signed({1'b0, scaled_reg});
    assign diff_neg   = -diff;
    assign mag_deg    = diff[8] ? diff_neg[7:0] : diff[7:0];
    assign deg_prod   = num_reg * tsc_pkg::DEG_MULT;
    assign temp       = neg_reg ? (tsc_pkg::TEMP_BIAS - $signed({1'b0, quot_reg}))
                                : (tsc_pkg::TEMP_BIAS + $signed({1'b0, quot_reg}));

    // Direction and duty follow from the stored control level.
    always_comb
    begin
        if (level_reg > tsc_pkg::LEVEL_CENTER)
        begin
            dir = tsc_pkg::DIR_HIGH;
            mag = level_reg - tsc_pkg::LEVEL_CENTER;
        end
        else if (level_reg < tsc_pkg::LEVEL_CENTER)
        begin
            dir = tsc_pkg::DIR_LOW;
            mag = tsc_pkg::LEVEL_CENTER - level_reg;
        end
        else
        begin
            dir = dir_reg;
            mag = '0;
        end
        if (dir == tsc_pkg::DIR_HIGH)
        begin
            duty = (mag >= tsc_pkg::DIR_HIGH_MAG_CAP) ? tsc_pkg::DIR_HIGH_DUTY_CAP
                                                      : 8'(mag * 2'd3);
        end
        else
        begin
            duty = (mag >= tsc_pkg::DIR_LOW_MAG_CAP) ? tsc_pkg::DIR_LOW_DUTY_CAP
                                                     : 8'(mag * 2'd2);
        end
    end

    // Sequencer: next state, queue pop, level step and output load.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        level_next = level_reg;
        dir_next   = dir_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            tsc_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = tsc_pkg::BK_SCALE;
                end
            end
            tsc_pkg::BK_SCALE:
            begin
                state_next = tsc_pkg::BK_MAG;
            end
            tsc_pkg::BK_MAG:
            begin
                state_next = tsc_pkg::BK_QUOT;
            end
            tsc_pkg::BK_QUOT:
            begin
                state_next = tsc_pkg::BK_LEVEL;
            end
            tsc_pkg::BK_LEVEL:
            begin
                if (temp < target)
                begin
                    level_next = (level_reg <= tsc_pkg::LEVEL_LOW_STEP) ? tsc_pkg::LEVEL_MIN
                                                                        : level_reg - 1'b1;
                end
                else if (temp > target)
                begin
                    level_next = (level_reg >= tsc_pkg::LEVEL_HIGH_STEP) ? tsc_pkg::LEVEL_MAX
                                                                         : level_reg + 1'b1;
                end
                state_next = tsc_pkg::BK_PUSH;
            end
            tsc_pkg::BK_PUSH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    dir_next   = dir;
                    state_next = tsc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tsc_pkg::BK_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !results.ready);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsc_pkg::BK_IDLE;
            level_reg     <= tsc_pkg::LEVEL_CENTER;
            dir_reg       <= tsc_pkg::DIR_HIGH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, at most one multiply per stage.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg <= queue_sum * AvgMult;
        end
        if (state_reg == tsc_pkg::BK_SCALE)
        begin
            scaled_reg <= scale_prod[tsc_pkg::SCALE_SHIFT +: 8];
        end
        if (state_reg == tsc_pkg::BK_MAG)
        begin
            neg_reg <= diff[8];
            num_reg <= mag_deg * tsc_pkg::DEG_NUM;
        end
        if (state_reg == tsc_pkg::BK_QUOT)
        begin
            quot_reg <= deg_prod[tsc_pkg::DEG_SHIFT +: QW];
        end
        if (state_reg == tsc_pkg::BK_LEVEL)
        begin
            temp_reg <= temp;
        end
        if (out_load)
        begin
            out_duty_reg  <= duty;
            out_dir_reg   <= dir;
            out_temp_reg  <= temp_reg;
            out_level_reg <= level_reg;
        end
    end

    // Output register toward the result channel.
    assign results.valid         = out_valid_reg;
    assign results.duty          = out_duty_reg;
    assign results.direction     = out_dir_reg;
    assign results.temperature   = out_temp_reg;
    assign results.control_level = out_level_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // One result transaction: the fields the block reports per completed average.
    typedef struct packed {
        logic [tsc_pkg::DUTY_WIDTH-1:0]         duty;
        logic                                   direction;
        logic signed [tsc_pkg::TEMP_WIDTH-1:0]  temperature;
        logic [tsc_pkg::LEVEL_WIDTH-1:0]        control_level;
    } reading_t;

    // A directed row either sends one sample or rewrites the target temperature.
    typedef enum logic {ROW_SAMPLE, ROW_TARGET} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        int         value;
        bit         has_typed;
        reading_t   typed;
    } row_t;

    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       SETTLE_CYCLES  = 12;
    localparam int       HOLD_CYCLES    = 300;
    localparam int       NUM_ROWS       = 22;
    localparam reading_t NO_READING     = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic signed [tsc_pkg::TEMP_WIDTH-1:0] cfg_wdata;

    tsc_sample_if sample_ch();
    tsc_result_if result_ch();

    thermal_step_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    // Controller state mirrored by the predictor.
    logic [13:0]                           acc_sum    = '0;
    int                                    acc_count  = 0;
    logic [tsc_pkg::LEVEL_WIDTH-1:0]       ctl_level  = tsc_pkg::LEVEL_CENTER;
    logic                                  ctl_dir    = tsc_pkg::DIR_HIGH;
    logic signed [tsc_pkg::TEMP_WIDTH-1:0] ctl_target = tsc_pkg::TARGET_RESET;

    reading_t reading_q[$];
    int       error_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    bit       hold_req       = 1'b0;
    int       quiet_cycles   = 0;

    // Directed stimulus. Typed expectations cover the reset state, the two
    // extremes of the sample, the exact-center level and a temperature equal
    // to the target; the remaining rows go through the predictor.
    row_t directed_rows [NUM_ROWS] = '{
        '{ROW_SAMPLE, 0,    1'b0, NO_READING},
        '{ROW_SAMPLE, 0,    1'b0, NO_READING},
        '{ROW_SAMPLE, 0,    1'b0, NO_READING},
        '{ROW_SAMPLE, 0,    1'b1, '{8'd3, tsc_pkg::DIR_HIGH, 10'sd351, 8'd129}},
        '{ROW_SAMPLE, 4095, 1'b0, NO_READING},
        '{ROW_SAMPLE, 4095, 1'b0, NO_READING},
        '{ROW_SAMPLE, 4095, 1'b0, NO_READING},
        '{ROW_SAMPLE, 4095, 1'b1, '{8'd0, tsc_pkg::DIR_HIGH, -10'sd220, 8'd128}},
        '{ROW_SAMPLE, 4095, 1'b0, NO_READING},
        '{ROW_SAMPLE, 4095, 1'b0, NO_READING},
        '{ROW_SAMPLE, 4095, 1'b0, NO_READING},
        '{ROW_SAMPLE, 4095, 1'b1, '{8'd2, tsc_pkg::DIR_LOW, -10'sd220, 8'd127}},
        '{ROW_TARGET, 351,  1'b0, NO_READING},
        '{ROW_SAMPLE, 0,    1'b0, NO_READING},
        '{ROW_SAMPLE, 16,   1'b0, NO_READING},
        '{ROW_SAMPLE, 16,   1'b0, NO_READING},
        '{ROW_SAMPLE, 32,   1'b1, '{8'd2, tsc_pkg::DIR_LOW, 10'sd351, 8'd127}},
        '{ROW_SAMPLE, 2730, 1'b0, NO_READING},
        '{ROW_SAMPLE, 1365, 1'b0, NO_READING},
        '{ROW_SAMPLE, 2730, 1'b0, NO_READING},
        '{ROW_SAMPLE, 1365, 1'b0, NO_READING},
        '{ROW_SAMPLE, 4095, 1'b0, NO_READING}
    };

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Adds one sample to the running group and, when the group closes,
    // works out the reading the block must report.
    function automatic bit predict_reading(input logic [tsc_pkg::ADC_WIDTH-1:0] s,
                                           output reading_t r);
        int avg_i;
        int scaled;
        int deg;
        int tgt;
        int lvl;
        int mag;
        int duty_i;
        r = '0;
        acc_sum = acc_sum + s;
        acc_count++;
        if (acc_count < tsc_pkg::SAMPLES_PER_AVERAGE)
            return 1'b0;
        avg_i = acc_sum / tsc_pkg::SAMPLES_PER_AVERAGE;
        acc_sum = '0;
        acc_count = 0;

        // Degrees: unsigned scaling first, then a signed divide toward zero.
        scaled = (avg_i * 250) / 4096;
        deg = ((142 - scaled) * 1000) / 435 + 25;

        // Step the level toward balance and clamp it.
        tgt = int'(ctl_target);
        lvl = int'(ctl_level);
        if (deg < tgt)
            lvl--;
        else if (deg > tgt)
            lvl++;
        if (lvl < int'(tsc_pkg::LEVEL_MIN))
            lvl = int'(tsc_pkg::LEVEL_MIN);
        if (lvl > int'(tsc_pkg::LEVEL_MAX))
            lvl = int'(tsc_pkg::LEVEL_MAX);
        ctl_level = lvl[tsc_pkg::LEVEL_WIDTH-1:0];

        // The direction holds its old value at the exact center.
        if (lvl > int'(tsc_pkg::LEVEL_CENTER))
        begin
            ctl_dir = tsc_pkg::DIR_HIGH;
            mag = lvl - int'(tsc_pkg::LEVEL_CENTER);
        end
        else if (lvl < int'(tsc_pkg::LEVEL_CENTER))
        begin
            ctl_dir = tsc_pkg::DIR_LOW;
            mag = int'(tsc_pkg::LEVEL_CENTER) - lvl;
        end
        else
        begin
            mag = 0;
        end

        if (ctl_dir == tsc_pkg::DIR_HIGH)
            duty_i = (mag >= int'(tsc_pkg::DIR_HIGH_MAG_CAP)) ?
                     int'(tsc_pkg::DIR_HIGH_DUTY_CAP) : mag * 3;
        else
            duty_i = (mag >= int'(tsc_pkg::DIR_LOW_MAG_CAP)) ?
                     int'(tsc_pkg::DIR_LOW_DUTY_CAP) : mag * 2;

        r.duty          = duty_i[tsc_pkg::DUTY_WIDTH-1:0];
        r.direction     = ctl_dir;
        r.temperature   = deg[tsc_pkg::TEMP_WIDTH-1:0];
        r.control_level = ctl_level;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Random sample, weighted toward the extremes and the low corner where the
    // hottest reading comes out.
    function automatic logic [tsc_pkg::ADC_WIDTH-1:0] pick_sample();
        int unsigned v;
        case ($urandom_range(15))
            0: v = 0;
            1: v = 4095;
            2: v = $urandom_range(16);
            3: v = $urandom_range(4095, 4000);
            default: v = $urandom_range(4095);
        endcase
        return v[tsc_pkg::ADC_WIDTH-1:0];
    endfunction

    // Offers one sample transaction. Called and returns at a falling edge;
    // valid is left high so the next call can follow without a gap.
    task automatic send_sample(input logic [tsc_pkg::ADC_WIDTH-1:0] s, input bit has_typed,
                               input reading_t typed);
        reading_t r;
        bit       closes_group;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        closes_group = predict_reading(s, r);
        if (closes_group)
            reading_q.push_back(has_typed ? typed : r);
        @(negedge clk);
    endtask

    // Rewrites the target once the block has gone quiet. Called at a falling edge.
    task automatic set_target(input int tgt);
        sample_ch.valid <= 1'b0;
        while (reading_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= tgt[tsc_pkg::TEMP_WIDTH-1:0];
        @(posedge clk);
        ctl_target = tgt[tsc_pkg::TEMP_WIDTH-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int tgt, input int s_idle, input int r_stall, input int n,
                             input bit squeeze);
        set_target(tgt);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        if (squeeze)
            hold_req = 1'b1;
        repeat (n) send_sample(pick_sample(), 1'b0, NO_READING);
    endtask

    // Result side ready: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each result transaction with the oldest pending reading.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (reading_q.size() == 0)
            begin
                report_mismatch("result transaction with no completed sample group pending");
            end
            else
            begin
                want = reading_q.pop_front();
                if (result_ch.duty !== want.duty)
                    report_mismatch($sformatf("duty got %0d want %0d",
                                              result_ch.duty, want.duty));
                if (result_ch.direction !== want.direction)
                    report_mismatch($sformatf("direction got %0b want %0b",
                                              result_ch.direction, want.direction));
                if (result_ch.temperature !== want.temperature)
                    report_mismatch($sformatf("temperature got %0d want %0d",
                                              result_ch.temperature, want.temperature));
                if (result_ch.control_level !== want.control_level)
                    report_mismatch($sformatf("control_level got %0d want %0d",
                                              result_ch.control_level, want.control_level));
            end
        end
    end

    // Watchdog: cycles in a row with no transaction on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, no idling.
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_TARGET)
                set_target(directed_rows[i].value);
            else
                send_sample(directed_rows[i].value[tsc_pkg::ADC_WIDTH-1:0],
                            directed_rows[i].has_typed, directed_rows[i].typed);
        end

        // Hottest target drives the level down to its floor, the coldest one
        // takes it all the way up to the ceiling across the idling phases.
        run_phase(351, 0, 0, 540, 1'b0);
        run_phase(-220, 84, 0, 300, 1'b0);
        run_phase(-220, 0, 84, 300, 1'b0);
        run_phase(-220, 10, 10, 460, 1'b0);

        // Long output hold-off while samples keep coming, then random targets.
        run_phase(int'($urandom_range(571)) - 220, 0, 0, 60, 1'b1);
        run_phase(int'($urandom_range(571)) - 220, 10, 10, 40, 1'b0);
        run_phase(int'($urandom_range(571)) - 220, 84, 0, 20, 1'b0);
        sample_ch.valid <= 1'b0;

        // Drain and let the pipeline settle before the verdict.
        while (reading_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES + 8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tsc_pkg.sv
sv/tsc_sample_if.sv
sv/tsc_result_if.sv
sv/tsc_fifo.sv
sv/tsc_front.sv
sv/tsc_back.sv
sv/thermal_step_controller.sv
tb/tb_top.sv
